FILE: hw/rtl/fasta_kmer_extractor_defines.svh
// Assertion macros for the k-mer extractor checker.
`ifndef FASTA_KMER_EXTRACTOR_DEFINES_SVH
`define FASTA_KMER_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FKE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("k-mer extractor assertion failed");

// Next-cycle implication, disabled during reset.
`define FKE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("k-mer extractor assertion failed");

// Next-cycle implication that also holds through reset.
`define FKE_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("k-mer extractor assertion failed");

`endif

FILE: hw/rtl/fke_pkg.sv
`default_nettype none
package fke_pkg;

   localparam int KMER_LEN = 15;
   localparam int WIN_W    = 2 * KMER_LEN;
   localparam int RUN_W    = $clog2(KMER_LEN + 1);
   localparam int OUT_W    = 30;
   localparam int EXT_W    = (WIN_W > OUT_W) ? WIN_W : OUT_W;
   localparam int CHAR_W   = 8;

   localparam logic [CHAR_W-1:0] CHAR_NL = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_GT = 8'h3E;
   localparam logic [CHAR_W-1:0] CHAR_A_UC = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_C_UC = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_G_UC = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_T_UC = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_U_UC = 8'h55;
   localparam logic [CHAR_W-1:0] CHAR_A_LC = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_C_LC = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_G_LC = 8'h67;
   localparam logic [CHAR_W-1:0] CHAR_T_LC = 8'h74;
   localparam logic [CHAR_W-1:0] CHAR_U_LC = 8'h75;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   typedef struct packed {
      logic       is_newline;
      logic       is_gt;
      logic       is_base;
      logic [1:0] base;
   } byte_class_type;

endpackage
`default_nettype wire

FILE: hw/rtl/fasta_kmer_extractor.sv
// Pipeline: a byte that completes a k-mer goes from the input register, through
//   the parse/window update, into the result register that drives rsp_.
// Throughput: one byte per cycle; the input stalls only while a result waits.
// Reset: synchronous; clears both windows and the base run, leaves the parser
//   at line start outside a header, and empties both pipeline registers.
`default_nettype none
module fasta_kmer_extractor
   import fke_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CHAR_W-1:0] req_char_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [OUT_W-1:0]       rsp_forward_kmer,
   output logic [OUT_W-1:0]       rsp_revcomp_kmer
);

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]  out_fwd_ff;
   logic [OUT_W-1:0]  out_rc_ff;

   logic              advance;
   logic              step;
   logic              emit;
   logic [OUT_W-1:0]  fwd_kmer;
   logic [OUT_W-1:0]  rc_kmer;
   byte_class_type    char_class;

   // the held byte moves on whenever the result slot is free or being drained
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   fke_decode u_decode (
      .char_byte  (in_char_ff),
      .char_class (char_class)
   );

   fke_window u_window (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .char_class   (char_class),
      .emit         (emit),
      .forward_kmer (fwd_kmer),
      .revcomp_kmer (rc_kmer)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall)
         in_valid_in = req_valid;
      out_valid_in = out_valid_ff;
      if (advance)
         out_valid_in = step && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall)
         in_char_ff <= req_char_byte;
      if (step && emit) begin
         out_fwd_ff <= fwd_kmer;
         out_rc_ff  <= rc_kmer;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_forward_kmer = out_fwd_ff;
   assign rsp_revcomp_kmer = out_rc_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/fke_decode.sv
`default_nettype none
module fke_decode
   import fke_pkg::*;
(
   input  wire logic [CHAR_W-1:0] char_byte,
   output byte_class_type         char_class
);

   always_comb begin
      char_class            = '0;
      char_class.is_newline = (char_byte == CHAR_NL);
      char_class.is_gt      = (char_byte == CHAR_GT);
      case (char_byte)
         CHAR_A_UC, CHAR_A_LC: begin
            char_class.is_base = 1'b1;
            char_class.base    = BASE_A;
         end
         CHAR_C_UC, CHAR_C_LC: begin
            char_class.is_base = 1'b1;
            char_class.base    = BASE_C;
         end
         CHAR_G_UC, CHAR_G_LC: begin
            char_class.is_base = 1'b1;
            char_class.base    = BASE_G;
         end
         CHAR_T_UC, CHAR_T_LC, CHAR_U_UC, CHAR_U_LC: begin
            char_class.is_base = 1'b1;
            char_class.base    = BASE_T;
         end
         default: begin
            char_class.is_base = 1'b0;
            char_class.base    = BASE_A;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/fke_window.sv
`default_nettype none
module fke_window
   import fke_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire byte_class_type   char_class,
   output logic                  emit,
   output logic [OUT_W-1:0]      forward_kmer,
   output logic [OUT_W-1:0]      revcomp_kmer
);

   logic [WIN_W-1:0] fwd_ff, fwd_in;
   logic [WIN_W-1:0] rc_ff, rc_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             line_start_ff, line_start_in;
   logic             in_header_ff, in_header_in;

   logic [WIN_W+1:0] fwd_shift;
   logic [EXT_W-1:0] fwd_ext;
   logic [EXT_W-1:0] rc_ext;

   always_comb begin
      fwd_in        = fwd_ff;
      rc_in         = rc_ff;
      run_in        = run_ff;
      line_start_in = line_start_ff;
      in_header_in  = in_header_ff;
      emit          = 1'b0;
      fwd_shift     = {fwd_ff, char_class.base};

      if (char_class.is_newline) begin
         in_header_in  = 1'b0;
         line_start_in = 1'b1;
      end else if (line_start_ff && char_class.is_gt) begin
         in_header_in  = 1'b1;
         line_start_in = 1'b0;
         fwd_in        = '0;
         rc_in         = '0;
         run_in        = '0;
      end else begin
         line_start_in = 1'b0;
         if (!in_header_ff) begin
            if (!char_class.is_base) begin
               fwd_in = '0;
               rc_in  = '0;
               run_in = '0;
            end else begin
               fwd_in = fwd_shift[WIN_W-1:0];
               // complement enters at the top, oldest falls off the bottom
               rc_in  = (rc_ff >> 2) | (WIN_W'(~char_class.base) << (WIN_W - 2));
               if (run_ff < RUN_W'(KMER_LEN))
                  run_in = run_ff + RUN_W'(1);
               emit = (run_in == RUN_W'(KMER_LEN));
            end
         end
      end
   end

   assign fwd_ext      = EXT_W'(fwd_in);
   assign rc_ext       = EXT_W'(rc_in);
   assign forward_kmer = fwd_ext[OUT_W-1:0];
   assign revcomp_kmer = rc_ext[OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff        <= '0;
         rc_ff         <= '0;
         run_ff        <= '0;
         line_start_ff <= 1'b1;
         in_header_ff  <= 1'b0;
      end else if (step) begin
         fwd_ff        <= fwd_in;
         rc_ff         <= rc_in;
         run_ff        <= run_in;
         line_start_ff <= line_start_in;
         in_header_ff  <= in_header_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/fke_checker.sv
`default_nettype none
`include "fasta_kmer_extractor_defines.svh"
module fke_checker
   import fke_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic [CHAR_W-1:0] req_char_byte,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [OUT_W-1:0]  rsp_forward_kmer,
   input wire logic [OUT_W-1:0]  rsp_revcomp_kmer
);

   logic req_xfer;
   logic req_held;
   logic rsp_held;

   assign req_xfer = req_valid && !req_stall;
   assign req_held = req_valid && req_stall;
   assign rsp_held = rsp_valid && rsp_stall;

   // a stalled byte stays offered and unchanged
   `FKE_ASSERT_NXT(a_req_hold, clock, reset, req_held,
      req_valid && $stable(req_char_byte))

   // a stalled result keeps both k-mers
   `FKE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_held,
      $stable(rsp_forward_kmer) && $stable(rsp_revcomp_kmer))

   // a new result must follow an accepted byte that passed the input and result registers
   `FKE_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_xfer, 2))

   // input backpressure only comes from a blocked result
   `FKE_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_held)

   // reset empties the pipeline
   `FKE_ASSERT_NXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

endmodule

bind fasta_kmer_extractor fke_checker u_fke_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_char_byte    (req_char_byte),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_forward_kmer (rsp_forward_kmer),
   .rsp_revcomp_kmer (rsp_revcomp_kmer)
);
`default_nettype wire
